// File: rtl/tgcc_pkg.sv
// Shared widths, register indexes and reset values of the text/graphic/cursor compositor.
`default_nettype none

package tgcc_pkg;

    // Field widths of the pixel and write channels.
    localparam int POS_W  = 12;
    localparam int PIX_W  = 16;
    localparam int ADDR_W = 24;

    // Configuration port and register widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FB_DIM_W    = 13;
    localparam int CUR_COL_W   = 9;
    localparam int CUR_LINE_W  = 8;

    // Width of a clamped framebuffer dimension (holds values up to 16383).
    localparam int DIM_W = 14;

    // Reset values of the registers.
    localparam logic [FB_DIM_W-1:0] FB_COLUMNS_RST   = 13'd640;
    localparam logic [FB_DIM_W-1:0] FB_ROWS_RST      = 13'd480;
    localparam logic [PIX_W-1:0]    CURSOR_COLOR_RST = 16'h8410;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FB_COLUMNS    = 3'd0,
        CFG_FB_ROWS       = 3'd1,
        CFG_EXPAND_MODE   = 3'd2,
        CFG_CURSOR_SHOWN  = 3'd3,
        CFG_CURSOR_COLUMN = 3'd4,
        CFG_CURSOR_LINE   = 3'd5,
        CFG_CURSOR_COLOR  = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/tgcc_in_if.sv
// Pixel input channel: one display position with its text and graphic plane values.
`default_nettype none

interface tgcc_in_if
    import tgcc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] text_pixel;
    logic [PIX_W-1:0] graphic_pixel;

    modport source (output valid, output pos_x, output pos_y, output text_pixel,
                    output graphic_pixel, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input text_pixel,
                    input graphic_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/tgcc_out_if.sv
// Framebuffer write channel: address and pixel pairs with a last-write flag.
`default_nettype none

interface tgcc_out_if
    import tgcc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] fb_address;
    logic [PIX_W-1:0]  out_pixel;
    logic              last_write;

    modport source (output valid, output fb_address, output out_pixel,
                    output last_write, input ready);
    modport sink   (input valid, input fb_address, input out_pixel,
                    input last_write, output ready);
endinterface

`default_nettype wire

// File: rtl/text_graphic_cursor_compositor.sv
// Top level: composites text, cursor and graphic planes and emits framebuffer writes.
//
// Usage:
//   pixel    - valid/ready sink; each beat carries one display position plus its
//              text-plane and graphic-plane values.
//   fb_write - valid/ready source; each beat is one framebuffer write (address,
//              pixel value, last_write on the final write of an input beat).
//   cfg_*    - plain write port; write only while the block is idle.
// An accepted pixel beat moves through the stage registers to the output register
// before its first write beat. In normal mode one pixel beat is accepted every cycle
// while fb_write is ready. In expand mode each pixel gives a 2x2 block of four writes,
// sent one per cycle from the output register while fb_write is ready; meanwhile
// later pixel beats wait in the earlier stages. Positions outside the active area are
// dropped in the second stage and give no write. Reset empties the pipeline and loads
// the register defaults (640x480, no expand, cursor hidden at cell 0,0, mid gray
// cursor color). When fb_write stalls, the stages fill up and then pixel.ready drops;
// no beat is lost or repeated.
`default_nettype none

module text_graphic_cursor_compositor
    import tgcc_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [CFG_INDEX_W-1:0] cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    tgcc_in_if.sink               pixel,
    tgcc_out_if.source            fb_write
);

    localparam logic [PIX_W-1:0] PIX_MASK = (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}}
                                          : PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);
    localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

    // Configuration registers.
    logic [FB_DIM_W-1:0]   fb_columns_reg;
    logic [FB_DIM_W-1:0]   fb_rows_reg;
    logic                  expand_mode_reg;
    logic                  cursor_shown_reg;
    logic [CUR_COL_W-1:0]  cursor_column_reg;
    logic [CUR_LINE_W-1:0] cursor_line_reg;
    logic [PIX_W-1:0]      cursor_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_columns_reg    <= FB_COLUMNS_RST;
            fb_rows_reg       <= FB_ROWS_RST;
            expand_mode_reg   <= 1'b0;
            cursor_shown_reg  <= 1'b0;
            cursor_column_reg <= '0;
            cursor_line_reg   <= '0;
            cursor_color_reg  <= CURSOR_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FB_COLUMNS:    fb_columns_reg    <= cfg_data[FB_DIM_W-1:0];
                CFG_FB_ROWS:       fb_rows_reg       <= cfg_data[FB_DIM_W-1:0];
                CFG_EXPAND_MODE:   expand_mode_reg   <= cfg_data[0];
                CFG_CURSOR_SHOWN:  cursor_shown_reg  <= cfg_data[0];
                CFG_CURSOR_COLUMN: cursor_column_reg <= cfg_data[CUR_COL_W-1:0];
                CFG_CURSOR_LINE:   cursor_line_reg   <= cfg_data[CUR_LINE_W-1:0];
                CFG_CURSOR_COLOR:  cursor_color_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamped stride and active area; user must keep them static while items are in flight; not enforced.
    logic [DIM_W-1:0] stride;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] active_w;
    logic [DIM_W-1:0] active_h;

    always_comb
    begin
        stride   = ({1'b0, fb_columns_reg} > MAX_DIM_C) ? MAX_DIM_C : {1'b0, fb_columns_reg};
        rows     = ({1'b0, fb_rows_reg} > MAX_DIM_C) ? MAX_DIM_C : {1'b0, fb_rows_reg};
        active_w = expand_mode_reg ? {1'b0, stride[DIM_W-1:1]} : stride;
        active_h = expand_mode_reg ? {1'b0, rows[DIM_W-1:1]} : rows;
    end

    // Pipeline registers.
    logic                  s1_valid_reg;
    logic [POS_W-1:0]      s1_x_reg;
    logic [POS_W-1:0]      s1_y_reg;
    logic [PIX_W-1:0]      s1_text_reg;
    logic [PIX_W-1:0]      s1_graphic_reg;

    logic                  s2_valid_reg;
    logic [ADDR_W-1:0]     s2_row_addr_reg;
    logic [POS_W:0]        s2_col_reg;
    logic [PIX_W-1:0]      s2_pix_reg;

    logic                  s3_valid_reg;
    logic [ADDR_W-1:0]     s3_base_reg;
    logic [PIX_W-1:0]      s3_pix_reg;

    logic                  s4_valid_reg;
    logic [ADDR_W-1:0]     s4_base_reg;
    logic [ADDR_W-1:0]     s4_addr_reg;
    logic [PIX_W-1:0]      s4_pix_reg;
    logic [1:0]            s4_cnt_reg;

    // Each stage loads when it is empty or its content moves on this cycle.
    logic s4_last;
    logic s4_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;

    assign s4_last = !expand_mode_reg || (s4_cnt_reg == 2'd3);
    assign s4_free = !s4_valid_reg || (fb_write.ready && s4_last);
    assign s3_free = !s3_valid_reg || s4_free;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;

    assign pixel.ready = s1_free;

    // Stage 1: capture the pixel beat, with plane values masked to the pixel width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && pixel.valid)
        begin
            s1_x_reg       <= pixel.pos_x;
            s1_y_reg       <= pixel.pos_y;
            s1_text_reg    <= pixel.text_pixel & PIX_MASK;
            s1_graphic_reg <= pixel.graphic_pixel & PIX_MASK;
        end
    end

    // Stage 2: area check, cursor and plane composition, row address multiply.
    logic                  in_area;
    logic                  cursor_hit;
    logic [PIX_W-1:0]      comp_pix;
    logic [POS_W:0]        row_scaled;
    logic [POS_W:0]        col_scaled;
    logic [POS_W+DIM_W:0]  row_product;

    always_comb
    begin
        in_area    = ({{(DIM_W-POS_W){1'b0}}, s1_x_reg} < active_w)
                  && ({{(DIM_W-POS_W){1'b0}}, s1_y_reg} < active_h);
        // The 8x16 cell test reduces to matching the upper position bits.
        cursor_hit = cursor_shown_reg
                  && (s1_x_reg[POS_W-1:3] == cursor_column_reg)
                  && (s1_y_reg[POS_W-1:4] == cursor_line_reg);
        comp_pix   = s1_text_reg;
        if ((comp_pix == '0) && cursor_hit)
        begin
            comp_pix = cursor_color_reg & PIX_MASK;
        end
        if (comp_pix == '0)
        begin
            comp_pix = s1_graphic_reg;
        end
        row_scaled  = expand_mode_reg ? {s1_y_reg, 1'b0} : {1'b0, s1_y_reg};
        col_scaled  = expand_mode_reg ? {s1_x_reg, 1'b0} : {1'b0, s1_x_reg};
        row_product = row_scaled * stride;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg && in_area;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_row_addr_reg <= row_product[ADDR_W-1:0];
            s2_col_reg      <= col_scaled;
            s2_pix_reg      <= comp_pix;
        end
    end

    // Stage 3: base address of the write or of the 2x2 block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            s3_base_reg <= s2_row_addr_reg + {{(ADDR_W-POS_W-1){1'b0}}, s2_col_reg};
            s3_pix_reg  <= s2_pix_reg;
        end
    end

    // Stage 4: output register; in expand mode it steps through the 2x2 block.
    logic [1:0]        cnt_next;
    logic [ADDR_W-1:0] offset_next;

    always_comb
    begin
        cnt_next    = s4_cnt_reg + 2'd1;
        offset_next = (cnt_next[1] ? {{(ADDR_W-DIM_W){1'b0}}, stride} : '0)
                    + {{(ADDR_W-1){1'b0}}, cnt_next[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s4_cnt_reg   <= 2'd0;
        end
        else if (s4_free)
        begin
            s4_valid_reg <= s3_valid_reg;
            s4_cnt_reg   <= 2'd0;
        end
        else if (fb_write.ready)
        begin
            s4_cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_free)
        begin
            if (s3_valid_reg)
            begin
                s4_base_reg <= s3_base_reg;
                s4_addr_reg <= s3_base_reg;
                s4_pix_reg  <= s3_pix_reg;
            end
        end
        else if (fb_write.ready)
        begin
            s4_addr_reg <= s4_base_reg + offset_next;
        end
    end

    assign fb_write.valid      = s4_valid_reg;
    assign fb_write.fb_address = s4_addr_reg;
    assign fb_write.out_pixel  = s4_pix_reg;
    assign fb_write.last_write = s4_last;

    // Without expand mode every write beat closes its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fb_write.valid && !expand_mode_reg) |-> fb_write.last_write)
        else $error("write beat without last_write outside expand mode");

    // A write that is not the last of its block is followed by another write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fb_write.valid && fb_write.ready && !fb_write.last_write) |=> fb_write.valid)
        else $error("2x2 block cut short");

    // Within a block each further write lands at an address other than the base, unless the stride is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fb_write.valid && fb_write.ready && !fb_write.last_write)
        |=> (fb_write.fb_address != $past(s4_base_reg)) || (stride == '0))
        else $error("2x2 block repeats its base address");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the text/graphic/cursor compositor: directed table, then random beats.
`default_nettype none

module tb_top
    import tgcc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM           = 4096;
    localparam int CELL_W            = 8;
    localparam int CELL_H            = 16;
    localparam int LATENCY_SLACK     = 8;
    localparam int SEGMENTS          = 12;
    localparam int ITEMS_PER_SEGMENT = 25;
    localparam int N_DIRECTED        = 38;
    localparam int MAX_REPORTS       = 40;

    // Register index past the end of the register file; writes to it are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] text;
        logic [PIX_W-1:0] graphic;
    } pix_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } fb_write_t;

    // A table row is a register write, a beat checked by the predictor,
    // or a beat whose single write (or none) is typed in by hand.
    typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        pix_item_t              item;
        logic [2:0]             n_writes;
        logic [ADDR_W-1:0]      addr;
        logic [PIX_W-1:0]       pix;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Reset settings: 640x480, cursor hidden.
        '{ROW_KNOWN, '0, '0, '{12'd0, 12'd0, 16'h0000, 16'h1234}, 3'd1, 24'd0, 16'h1234},
        '{ROW_KNOWN, '0, '0, '{12'd639, 12'd479, 16'hFFFF, 16'hFFFF}, 3'd1, 24'd307199,
          16'hFFFF},
        '{ROW_KNOWN, '0, '0, '{12'd640, 12'd0, 16'h1111, 16'h2222}, 3'd0, 24'd0, 16'h0000},
        '{ROW_KNOWN, '0, '0, '{12'd0, 12'd480, 16'h3333, 16'h4444}, 3'd0, 24'd0, 16'h0000},
        '{ROW_KNOWN, '0, '0, '{12'hFFF, 12'hFFF, 16'h5555, 16'h6666}, 3'd0, 24'd0, 16'h0000},
        '{ROW_KNOWN, '0, '0, '{12'd0, 12'd1, 16'h0000, 16'h0000}, 3'd1, 24'd640, 16'h0000},
        // Cursor shown in cell 0,0: edges of the 8x16 cell.
        '{ROW_CFG, CFG_CURSOR_SHOWN, 16'd1, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_KNOWN, '0, '0, '{12'd0, 12'd0, 16'h0000, 16'h5555}, 3'd1, 24'd0, 16'h8410},
        '{ROW_KNOWN, '0, '0, '{12'd7, 12'd15, 16'h0000, 16'h5555}, 3'd1, 24'd9607, 16'h8410},
        '{ROW_KNOWN, '0, '0, '{12'd8, 12'd15, 16'h0000, 16'h5555}, 3'd1, 24'd9608, 16'h5555},
        '{ROW_KNOWN, '0, '0, '{12'd7, 12'd16, 16'h0000, 16'h5555}, 3'd1, 24'd10247, 16'h5555},
        '{ROW_KNOWN, '0, '0, '{12'd3, 12'd3, 16'hABCD, 16'h0000}, 3'd1, 24'd1923, 16'hABCD},
        // Last cursor cell, oversized framebuffer that saturates at the limit.
        '{ROW_CFG, CFG_CURSOR_COLUMN, 16'd511, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_CURSOR_LINE, 16'd255, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_CURSOR_COLOR, 16'hFFFF, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_FB_COLUMNS, 16'd8191, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_FB_ROWS, 16'd5000, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'hFFF, 12'hFFF, 16'h0000, 16'h0000}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd4087, 12'hFFF, 16'h0000, 16'h00FF}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'hFFF, 12'd4079, 16'h0000, 16'h0F0F}, 3'd0, 24'd0, 16'h0000},
        // Expand mode with odd sizes: the active area is 3x2.
        '{ROW_CFG, CFG_EXPAND_MODE, 16'd1, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_FB_COLUMNS, 16'd7, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_FB_ROWS, 16'd5, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd2, 12'd1, 16'h0000, 16'hA5A5}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd3, 12'd0, 16'h0000, 16'hA5A5}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd0, 12'd2, 16'h0000, 16'hA5A5}, 3'd0, 24'd0, 16'h0000},
        // Zero width leaves no active area; a write past the register file changes nothing.
        '{ROW_CFG, CFG_FB_COLUMNS, 16'd0, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd0, 12'd0, 16'h0001, 16'h0001}, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_NO_REG, 16'hFFFF, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd0, 12'd0, 16'h0001, 16'h0001}, 3'd0, 24'd0, 16'h0000},
        // Full size in expand mode: highest address, and a cursor color of zero.
        '{ROW_CFG, CFG_FB_COLUMNS, 16'd4096, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_FB_ROWS, 16'd4096, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_CURSOR_COLUMN, 16'd255, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_CURSOR_LINE, 16'd127, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_CFG, CFG_CURSOR_COLOR, 16'h0000, '0, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd2047, 12'd2047, 16'h0000, 16'h7E7E}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd2048, 12'd0, 16'h0000, 16'h7E7E}, 3'd0, 24'd0, 16'h0000},
        '{ROW_PRED, '0, '0, '{12'd2046, 12'd2047, 16'h0000, 16'h0000}, 3'd0, 24'd0, 16'h0000}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tgcc_in_if  pixel_ch ();
    tgcc_out_if fbw_ch ();

    text_graphic_cursor_compositor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .fb_write  (fbw_ch)
    );

    // Our copy of the register file, starting from the reset values.
    logic [FB_DIM_W-1:0]   fb_cols_reg      = FB_COLUMNS_RST;
    logic [FB_DIM_W-1:0]   fb_rows_reg      = FB_ROWS_RST;
    logic                  expand_reg       = 1'b0;
    logic                  cursor_on_reg    = 1'b0;
    logic [CUR_COL_W-1:0]  cursor_col_reg   = '0;
    logic [CUR_LINE_W-1:0] cursor_line_reg  = '0;
    logic [PIX_W-1:0]      cursor_color_reg = CURSOR_COLOR_RST;

    fb_write_t fb_writes_due[$];
    int        fail_count    = 0;
    int        src_idle_pct  = 0;
    int        sink_idle_pct = 0;

    // Saturated dimension, halved in expand mode.
    function automatic int unsigned active_size(input int unsigned dim);
        int unsigned v;
        v = (dim > MAX_DIM) ? MAX_DIM : dim;
        return expand_reg ? v / 2 : v;
    endfunction

    // Queues the framebuffer writes one pixel beat causes; returns how many.
    function automatic int composite_writes(input pix_item_t it);
        int unsigned stride;
        int unsigned aw;
        int unsigned ah;
        int unsigned cx;
        int unsigned cy;
        int unsigned x;
        int unsigned y;
        logic [PIX_W-1:0]  pix;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] step;
        stride = 32'(fb_cols_reg);
        if (stride > MAX_DIM)
            stride = MAX_DIM;
        aw = active_size(32'(fb_cols_reg));
        ah = active_size(32'(fb_rows_reg));
        x = 32'(it.x);
        y = 32'(it.y);
        if (x >= aw || y >= ah)
            return 0;

        // Text first, then the cursor where text is transparent, then graphics.
        pix = it.text;
        if (pix == '0 && cursor_on_reg) begin
            cx = 32'(cursor_col_reg) * CELL_W;
            cy = 32'(cursor_line_reg) * CELL_H;
            if (x >= cx && x < cx + CELL_W && y >= cy && y < cy + CELL_H)
                pix = cursor_color_reg;
        end
        if (pix == '0)
            pix = it.graphic;

        if (!expand_reg) begin
            fb_writes_due.push_back(fb_write_t'{ADDR_W'(y * stride + x), pix, 1'b1});
            return 1;
        end
        // Expand mode covers a 2x2 block, top row first.
        base = ADDR_W'(2 * y * stride + 2 * x);
        step = ADDR_W'(stride);
        fb_writes_due.push_back(fb_write_t'{base, pix, 1'b0});
        fb_writes_due.push_back(fb_write_t'{base + 24'd1, pix, 1'b0});
        fb_writes_due.push_back(fb_write_t'{base + step, pix, 1'b0});
        fb_writes_due.push_back(fb_write_t'{base + step + 24'd1, pix, 1'b1});
        return 4;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_mask(input logic [CFG_INDEX_W-1:0] idx);
        case (idx)
            CFG_FB_COLUMNS, CFG_FB_ROWS:       return 16'h1FFF;
            CFG_EXPAND_MODE, CFG_CURSOR_SHOWN: return 16'h0001;
            CFG_CURSOR_COLUMN:                 return 16'h01FF;
            CFG_CURSOR_LINE:                   return 16'h00FF;
            CFG_CURSOR_COLOR:                  return 16'hFFFF;
            default:                           return 16'h0000;
        endcase
    endfunction

    function automatic logic [FB_DIM_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd1;
            1:       return 13'd2;
            2:       return 13'd3;
            3, 4, 5: return FB_DIM_W'($urandom_range(2, 40));
            6:       return FB_DIM_W'($urandom_range(1, 8191));
            7:       return 13'd4096;
            8:       return 13'd8191;
            default: return FB_DIM_W'($urandom_range(4000, 4100));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Register write with random bits above the register width, which must be dropped.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] word;
        word = val | (CFG_DATA_W'($urandom) & ~reg_mask(idx));
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FB_COLUMNS:    fb_cols_reg      = word[FB_DIM_W-1:0];
            CFG_FB_ROWS:       fb_rows_reg      = word[FB_DIM_W-1:0];
            CFG_EXPAND_MODE:   expand_reg       = word[0];
            CFG_CURSOR_SHOWN:  cursor_on_reg    = word[0];
            CFG_CURSOR_COLUMN: cursor_col_reg   = word[CUR_COL_W-1:0];
            CFG_CURSOR_LINE:   cursor_line_reg  = word[CUR_LINE_W-1:0];
            CFG_CURSOR_COLOR:  cursor_color_reg = word;
            default: ;
        endcase
    endtask

    // Drives one pixel beat after a random number of idle cycles and returns once it is taken.
    task automatic send_pixel(input pix_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid         <= 1'b1;
        pixel_ch.pos_x         <= it.x;
        pixel_ch.pos_y         <= it.y;
        pixel_ch.text_pixel    <= it.text;
        pixel_ch.graphic_pixel <= it.graphic;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    // Stops sending, waits until every queued write has come out, then waits out the LATENCY_SLACK margin.
    task automatic drain();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (fb_writes_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    initial begin : clock_gen
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Write side: random stalls, changed on the falling edge.
    initial begin : write_sink
        fbw_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            fbw_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Each accepted write beat is matched against the oldest queued write.
    always @(posedge clk) begin : check_writes
        fb_write_t due;
        if (fbw_ch.valid === 1'b1 && fbw_ch.ready === 1'b1) begin
            if (fb_writes_due.size() == 0) begin
                report_mismatch($sformatf("write beat to %h with none pending",
                                          fbw_ch.fb_address));
            end
            else begin
                due = fb_writes_due.pop_front();
                if (fbw_ch.fb_address !== due.addr)
                    report_mismatch($sformatf("fb_address %h, expected %h",
                                              fbw_ch.fb_address, due.addr));
                if (fbw_ch.out_pixel !== due.pix)
                    report_mismatch($sformatf("out_pixel %h at %h, expected %h",
                                              fbw_ch.out_pixel, due.addr, due.pix));
                if (fbw_ch.last_write !== due.last)
                    report_mismatch($sformatf("last_write %b at %h, expected %b",
                                              fbw_ch.last_write, due.addr, due.last));
            end
        end
    end

    initial begin : stimulus
        dir_row_t            row;
        pix_item_t           it;
        logic [FB_DIM_W-1:0] cols;
        logic [FB_DIM_W-1:0] rows;
        int unsigned         aw;
        int unsigned         ah;
        int unsigned         cx;
        int unsigned         cy;
        int                  pick;

        pixel_ch.valid         = 1'b0;
        pixel_ch.pos_x         = '0;
        pixel_ch.pos_y         = '0;
        pixel_ch.text_pixel    = '0;
        pixel_ch.graphic_pixel = '0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        rst_n                  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table.
        src_idle_pct  = 38;
        sink_idle_pct = 50;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG) begin
                if (i > 0 && DIRECTED_ROWS[i-1].kind != ROW_CFG)
                    drain();
                write_reg(row.reg_idx, row.reg_val);
            end
            else begin
                send_pixel(row.item);
                if (row.kind == ROW_PRED)
                    void'(composite_writes(row.item));
                else if (row.n_writes != 0)
                    fb_writes_due.push_back(fb_write_t'{row.addr, row.pix, 1'b1});
            end
        end

        // Random segments, each with fresh settings; the stall pattern changes every four.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin
                    src_idle_pct  = 38;
                    sink_idle_pct = 50;
                end
                1: begin
                    src_idle_pct  = 50;
                    sink_idle_pct = 38;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            drain();

            // Expand mode needs at least 2x2 so the active area is never empty.
            cols = random_dim();
            rows = random_dim();
            write_reg(CFG_EXPAND_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            if (expand_reg) begin
                if (cols < 2)
                    cols = 2;
                if (rows < 2)
                    rows = 2;
            end
            write_reg(CFG_FB_COLUMNS, CFG_DATA_W'(cols));
            write_reg(CFG_FB_ROWS, CFG_DATA_W'(rows));
            aw = active_size(32'(fb_cols_reg));
            ah = active_size(32'(fb_rows_reg));

            // Mostly keep the cursor inside the active area.
            write_reg(CFG_CURSOR_SHOWN, CFG_DATA_W'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 3) != 0) begin
                write_reg(CFG_CURSOR_COLUMN, CFG_DATA_W'($urandom_range(0, (aw - 1) / CELL_W)));
                write_reg(CFG_CURSOR_LINE, CFG_DATA_W'($urandom_range(0, (ah - 1) / CELL_H)));
            end
            else begin
                write_reg(CFG_CURSOR_COLUMN, CFG_DATA_W'($urandom_range(0, 511)));
                write_reg(CFG_CURSOR_LINE, CFG_DATA_W'($urandom_range(0, 255)));
            end
            write_reg(CFG_CURSOR_COLOR,
                      ($urandom_range(0, 5) == 0) ? 16'h0000 : CFG_DATA_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));

            // Positions: inside the area, around the cursor cell, or anywhere.
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
                pick       = $urandom_range(0, 99);
                it.text    = ($urandom_range(0, 1) == 0) ? '0 : PIX_W'($urandom);
                it.graphic = ($urandom_range(0, 7) == 0) ? '0 : PIX_W'($urandom);
                if (pick < 15) begin
                    it.x = POS_W'($urandom);
                    it.y = POS_W'($urandom);
                end
                else if (pick < 50 && cursor_on_reg) begin
                    cx   = 32'(cursor_col_reg) * CELL_W;
                    cy   = 32'(cursor_line_reg) * CELL_H;
                    it.x = POS_W'(cx + $urandom_range(0, CELL_W + 3) - 2);
                    it.y = POS_W'(cy + $urandom_range(0, CELL_H + 3) - 2);
                end
                else begin
                    it.x = POS_W'($urandom_range(0, aw - 1));
                    it.y = POS_W'($urandom_range(0, ah - 1));
                end
                send_pixel(it);
                void'(composite_writes(it));
                // Now and then hold off until the write side has caught up.
                if ($urandom_range(0, 59) == 0)
                    drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/tgcc_pkg.sv
rtl/tgcc_in_if.sv
rtl/tgcc_out_if.sv
rtl/text_graphic_cursor_compositor.sv
tb/tb_top.sv
